// ----- design/cfm_pkg.sv -----
// cfm_pkg: shared widths, reset values, register indexes and types of the
// crossing frequency meter. No dependencies.
package cfm_pkg;

  // Default sizes of the top-level parameters
  localparam int SAMPLE_BITS_DEF = 8;
  localparam int COUNT_BITS_DEF  = 32;

  // Fixed field widths
  localparam int LEVEL_W     = 8;   // trigger level register
  localparam int RATE_W      = 24;  // sample rate register
  localparam int AVG_W       = 8;   // average count register
  localparam int FRAC_W      = 8;   // fraction bits of a frequency
  localparam int FREQ_W      = 32;  // period term and mean result
  localparam int SUM_W       = 40;  // frequency accumulator
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 2;

  // Entries of the crossing queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Register reset values
  localparam logic [LEVEL_W-1:0] TRIGGER_RESET = 8'd128;
  localparam logic [RATE_W-1:0]  RATE_RESET    = 24'd1000000;
  localparam logic [AVG_W-1:0]   AVG_RESET     = 8'd100;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TRIGGER = 2'd0,
    REG_RATE    = 2'd1,
    REG_AVERAGE = 2'd2
  } cfg_reg_e;

  // Back-end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_TERM,
    BK_MEAN,
    BK_OUT
  } back_state_e;

  // Crossing queue fill status
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

// ----- design/cfm_front.sv -----
// cfm_front: accepts samples, counts them and detects rising crossings.
// Pushes the period length of each crossing into the queue. Uses cfm_pkg.
module cfm_front #(
  parameter int SAMPLE_BITS = cfm_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = cfm_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [SAMPLE_BITS-1:0]      sample_i,
  input  logic [cfm_pkg::LEVEL_W-1:0] trigger_level_i,
  input  cfm_pkg::queue_status_t      q_status_i,
  output logic                        push_o,
  output logic [COUNT_BITS-1:0]       push_count_o
);

  localparam int CMP_W = (SAMPLE_BITS > cfm_pkg::LEVEL_W) ? SAMPLE_BITS : cfm_pkg::LEVEL_W;

  logic [SAMPLE_BITS-1:0] prev_q, prev_d;
  logic [COUNT_BITS-1:0]  cnt_q, cnt_d;
  logic [COUNT_BITS-1:0]  cnt_inc;
  logic [CMP_W-1:0]       cur_ext, prev_ext, trig_ext;
  logic                   accept;
  logic                   crossing;

  // Hold off new samples while the queue has no room
  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i & ~in_stall_o;

  // Count includes the current sample and saturates
  assign cnt_inc = (cnt_q == {COUNT_BITS{1'b1}}) ? cnt_q : cnt_q + COUNT_BITS'(1);

  // Rising crossing: previous at or below level, current at or above
  assign cur_ext  = CMP_W'(sample_i);
  assign prev_ext = CMP_W'(prev_q);
  assign trig_ext = CMP_W'(trigger_level_i);
  assign crossing = (prev_ext <= trig_ext) && (cur_ext >= trig_ext);

  always_comb begin
    prev_d       = prev_q;
    cnt_d        = cnt_q;
    push_o       = 1'b0;
    push_count_o = cnt_inc;
    if (accept) begin
      prev_d = sample_i;
      if (crossing) begin
        push_o = 1'b1;
        cnt_d  = '0;
      end else begin
        cnt_d = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      cnt_q  <= '0;
    end else begin
      prev_q <= prev_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ----- design/cfm_fifo.sv -----
// cfm_fifo: short register queue of period lengths between front and back.
// Uses cfm_pkg for its depth and status type.
module cfm_fifo #(
  parameter int WIDTH = cfm_pkg::COUNT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [WIDTH-1:0]       push_data_i,
  input  logic                   pop_i,
  output logic [WIDTH-1:0]       pop_data_o,
  output cfm_pkg::queue_status_t status_o
);

  localparam int DEPTH = cfm_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CNT_W'(DEPTH));
  assign do_push        = push_i & ~status_o.full;
  assign do_pop         = pop_i & ~status_o.empty;
  assign pop_data_o     = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- design/cfm_div.sv -----
// cfm_div: restoring bit-serial unsigned divider, one quotient bit a cycle.
// Shared by the period term and the mean. Uses cfm_pkg for widths.
module cfm_div #(
  parameter int DIVISOR_W = cfm_pkg::COUNT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [cfm_pkg::SUM_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]      divisor_i,
  output logic                      done_o,
  output logic [cfm_pkg::SUM_W-1:0] quotient_o
);

  localparam int QW    = cfm_pkg::SUM_W;
  localparam int STEPW = $clog2(QW + 1);

  logic [QW-1:0]        quot_q, quot_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [DIVISOR_W-1:0] dsr_q, dsr_d;
  logic [STEPW-1:0]     step_q, step_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;

  // One restoring step: shift in next dividend bit, subtract if it fits
  assign trial = {rem_q, quot_q[QW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = (trial >= {1'b0, dsr_q});

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      step_d = STEPW'(QW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quot_d = {quot_q[QW-2:0], fits};
      rem_d  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      step_d = step_q - STEPW'(1);
      if (step_q == STEPW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quot_q;

endmodule

// ----- design/cfm_back.sv -----
// cfm_back: turns queued period lengths into frequency terms, accumulates
// them and emits the mean. Uses cfm_pkg and cfm_div.
module cfm_back #(
  parameter int COUNT_BITS = cfm_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cfm_pkg::queue_status_t       q_status_i,
  input  logic [COUNT_BITS-1:0]        q_count_i,
  output logic                         pop_o,
  input  logic [cfm_pkg::RATE_W-1:0]   sample_rate_i,
  input  logic [cfm_pkg::AVG_W-1:0]    average_count_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [cfm_pkg::FREQ_W-1:0]   mean_frequency_o
);

  localparam int SUM_W  = cfm_pkg::SUM_W;
  localparam int FREQ_W = cfm_pkg::FREQ_W;
  localparam int AVG_W  = cfm_pkg::AVG_W;

  cfm_pkg::back_state_e state_q, state_d;

  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [AVG_W-1:0]      seen_q, seen_d;
  logic                  out_valid_q, out_valid_d;
  logic [FREQ_W-1:0]     mean_q, mean_d;
  logic [AVG_W-1:0]      need;
  logic [AVG_W-1:0]      seen_inc;
  logic [SUM_W-1:0]      sum_add;
  logic                  div_start;
  logic [SUM_W-1:0]      div_dividend;
  logic [COUNT_BITS-1:0] div_divisor;
  logic                  div_done;
  logic [SUM_W-1:0]      div_quot;

  // A zero average count means every crossing reports
  assign need     = (average_count_i == '0) ? AVG_W'(1) : average_count_i;
  assign seen_inc = seen_q + AVG_W'(1);
  assign sum_add  = sum_q + SUM_W'(div_quot[FREQ_W-1:0]);

  cfm_div #(
    .DIVISOR_W (COUNT_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Sequencer: term division, accumulate, mean division, deliver
  always_comb begin
    state_d      = state_q;
    sum_d        = sum_q;
    seen_d       = seen_q;
    out_valid_d  = out_valid_q;
    mean_d       = mean_q;
    pop_o        = 1'b0;
    div_start    = 1'b0;
    div_dividend = SUM_W'({sample_rate_i, {cfm_pkg::FRAC_W{1'b0}}});
    div_divisor  = q_count_i;

    // Result taken downstream frees the output register
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      cfm_pkg::BK_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o     = 1'b1;
          div_start = 1'b1;
          state_d   = cfm_pkg::BK_TERM;
        end
      end
      cfm_pkg::BK_TERM: begin
        if (div_done) begin
          if (seen_inc >= need) begin
            div_start    = 1'b1;
            div_dividend = sum_add;
            div_divisor  = COUNT_BITS'(need);
            sum_d        = '0;
            seen_d       = '0;
            state_d      = cfm_pkg::BK_MEAN;
          end else begin
            sum_d   = sum_add;
            seen_d  = seen_inc;
            state_d = cfm_pkg::BK_IDLE;
          end
        end
      end
      cfm_pkg::BK_MEAN: begin
        if (div_done) begin
          state_d = cfm_pkg::BK_OUT;
        end
      end
      cfm_pkg::BK_OUT: begin
        // Quotient holds in the divider until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          mean_d      = div_quot[FREQ_W-1:0];
          state_d     = cfm_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = cfm_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cfm_pkg::BK_IDLE;
      sum_q       <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mean_q <= mean_d;
  end

  assign out_valid_o      = out_valid_q;
  assign mean_frequency_o = mean_q;

endmodule

// ----- design/crossing_frequency_meter_core.sv -----
// Crossing frequency meter. Every accepted sample is counted; a rising
// crossing of the trigger level hands the sample count of that period to a
// two-entry queue, and the back end divides sample_rate * 256 by it, sums the
// terms and, after average_count crossings, divides the sum by that count and
// reports the mean in Hz with 8 fraction bits. Each crossing runs through
// the shared bit-serial divider (40 quotient bits, one per cycle), and a
// crossing that completes an average runs through it again for the mean
// before the result appears; samples keep flowing until two crossings are
// waiting. Configure only while the block is idle.
module crossing_frequency_meter_core #(
  parameter int SAMPLE_BITS = cfm_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = cfm_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration writes
  input  logic                            cfg_we_i,
  input  logic [cfm_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [cfm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Sample requests
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [SAMPLE_BITS-1:0]          sample_i,
  // Result requests
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [cfm_pkg::FREQ_W-1:0]      mean_frequency_o
);

  logic [cfm_pkg::LEVEL_W-1:0] trigger_q;
  logic [cfm_pkg::RATE_W-1:0]  rate_q;
  logic [cfm_pkg::AVG_W-1:0]   avg_q;

  cfm_pkg::queue_status_t q_status;
  logic                   push;
  logic [COUNT_BITS-1:0]  push_count;
  logic                   pop;
  logic [COUNT_BITS-1:0]  pop_count;

  // Configuration registers; upper data bits beyond a register are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trigger_q <= cfm_pkg::TRIGGER_RESET;
      rate_q    <= cfm_pkg::RATE_RESET;
      avg_q     <= cfm_pkg::AVG_RESET;
    end else if (cfg_we_i) begin
      case (cfm_pkg::cfg_reg_e'(cfg_index_i))
        cfm_pkg::REG_TRIGGER: trigger_q <= cfg_data_i[cfm_pkg::LEVEL_W-1:0];
        cfm_pkg::REG_RATE:    rate_q    <= cfg_data_i[cfm_pkg::RATE_W-1:0];
        cfm_pkg::REG_AVERAGE: avg_q     <= cfg_data_i[cfm_pkg::AVG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cfm_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_i        (sample_i),
    .trigger_level_i (trigger_q),
    .q_status_i      (q_status),
    .push_o          (push),
    .push_count_o    (push_count)
  );

  cfm_fifo #(
    .WIDTH (COUNT_BITS)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_count),
    .pop_i       (pop),
    .pop_data_o  (pop_count),
    .status_o    (q_status)
  );

  cfm_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_status_i       (q_status),
    .q_count_i        (pop_count),
    .pop_o            (pop),
    .sample_rate_i    (rate_q),
    .average_count_i  (avg_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .mean_frequency_o (mean_frequency_o)
  );

endmodule

// ----- design/cfm_checker.sv -----
// cfm_checker: port-level checks of the crossing frequency meter, bound to
// the top level. Uses cfm_pkg for widths.
module cfm_checker #(
  parameter int SAMPLE_BITS = cfm_pkg::SAMPLE_BITS_DEF
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic [SAMPLE_BITS-1:0]     sample_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [cfm_pkg::FREQ_W-1:0] mean_frequency_o
);

  // Stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mean_frequency_o))
    else $error("stalled result changed or dropped");

  // Reset leaves no result pending and the input open
  a_reset_clean: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && !in_stall_o)
    else $error("result or stall present during reset");

  // The queue can only fill on an accepted sample
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall without a preceding accepted sample");

  // A stalled sample request stays offered and unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(sample_i))
    else $error("stalled sample changed or withdrawn");

endmodule

bind crossing_frequency_meter_core cfm_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_cfm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .sample_i         (sample_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .mean_frequency_o (mean_frequency_o)
);

// ----- test/tb_crossing_frequency_meter_core.sv -----
// Testbench for crossing_frequency_meter_core: directed and random sample
// streams, checked against a built-in model of the averaging frequency meter.
// Depends on cfm_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_crossing_frequency_meter_core;

  localparam int SAMPLE_W    = cfm_pkg::SAMPLE_BITS_DEF;
  localparam int COUNT_W     = cfm_pkg::COUNT_BITS_DEF;
  localparam int SAMPLE_TOP  = (1 << SAMPLE_W) - 1;
  localparam int SETTLE_CYC  = 250;      // back end worst case is two queued crossings
  localparam int HOLD_CYC    = 1500;     // long receiver hold-off
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_REPORTS = 10;
  localparam int DATA_W      = cfm_pkg::CFG_DATA_W;
  // index with no register behind it
  localparam logic [cfm_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [cfm_pkg::CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [DATA_W-1:0]               cfg_data_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic [SAMPLE_W-1:0]             sample_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [cfm_pkg::FREQ_W-1:0]      mean_frequency_o;

  crossing_frequency_meter_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_i        (sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .mean_frequency_o(mean_frequency_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shared state
  logic [SAMPLE_W-1:0]        sample_q[$];        // samples waiting to be offered
  logic [cfm_pkg::FREQ_W-1:0] mean_expect_q[$];   // predicted mean frequencies
  int                         idle_pct = 17;
  int                         err_cnt = 0;
  int                         hold_req = 0;
  int                         hold_ack = 0;
  int                         hold_left = 0;
  int                         cycle_cnt = 0;
  logic [cfm_pkg::FREQ_W-1:0] want_freq;

  // Meter model: configuration and running state
  logic [cfm_pkg::LEVEL_W-1:0] trig_lvl;
  logic [cfm_pkg::RATE_W-1:0]  rate_hz;
  logic [cfm_pkg::AVG_W-1:0]   avg_num;
  logic [SAMPLE_W-1:0]         level_prev;
  logic [COUNT_W-1:0]          period_count;
  logic [cfm_pkg::SUM_W-1:0]   freq_sum;
  logic [cfm_pkg::AVG_W-1:0]   crossing_cnt;

  task automatic note_error(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Count the sample; on a rising crossing add the period frequency and
  // emit the mean once enough crossings are in.
  function automatic void track_sample(input logic [SAMPLE_W-1:0] cur);
    logic [cfm_pkg::AVG_W-1:0] need;
    logic [cfm_pkg::SUM_W-1:0] divisor;
    logic [cfm_pkg::SUM_W-1:0] term;
    logic [cfm_pkg::SUM_W-1:0] mean;
    need = (avg_num == '0) ? cfm_pkg::AVG_W'(1) : avg_num;
    if (period_count != '1) period_count++;
    if (level_prev <= trig_lvl && cur >= trig_lvl) begin
      divisor = (period_count == '0) ? cfm_pkg::SUM_W'(1) : cfm_pkg::SUM_W'(period_count);
      term = (cfm_pkg::SUM_W'(rate_hz) << cfm_pkg::FRAC_W) / divisor;
      freq_sum = freq_sum + term;
      period_count = '0;
      crossing_cnt++;
      if (crossing_cnt >= need) begin
        mean = freq_sum / cfm_pkg::SUM_W'(need);
        mean_expect_q.push_back(mean[cfm_pkg::FREQ_W-1:0]);
        freq_sum = '0;
        crossing_cnt = '0;
      end
    end
    level_prev = cur;
  endfunction

  // Register write, mirrored into the model
  task automatic write_reg(input logic [cfm_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      cfm_pkg::REG_TRIGGER: trig_lvl = val[cfm_pkg::LEVEL_W-1:0];
      cfm_pkg::REG_RATE:    rate_hz  = val[cfm_pkg::RATE_W-1:0];
      cfm_pkg::REG_AVERAGE: avg_num  = val[cfm_pkg::AVG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [DATA_W-1:0] trig,
                           input logic [DATA_W-1:0] rate,
                           input logic [DATA_W-1:0] avg);
    write_reg(cfm_pkg::REG_TRIGGER, trig);
    write_reg(cfm_pkg::REG_RATE, rate);
    write_reg(cfm_pkg::REG_AVERAGE, avg);
  endtask

  // Wait until every sample is in and every mean is out, then let the
  // back end finish any crossing that produces no result. Checked at the
  // falling edge so the driver's updates are settled.
  task automatic drain();
    while (sample_q.size() != 0 || in_valid_i || mean_expect_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Square-ish wave around the trigger level with random run lengths,
  // occasional long periods and some fully random samples.
  task automatic push_wave(input int n, input int max_low, input int max_high,
                           input int noise_pct);
    int low_len;
    int high_len;
    int k;
    while (n > 0) begin
      low_len  = ($urandom_range(9, 0) == 0) ? $urandom_range(8 * max_low, 1)
                                              : $urandom_range(max_low, 1);
      high_len = $urandom_range(max_high, 1);
      for (k = 0; k < low_len + high_len && n > 0; k++) begin
        if ($urandom_range(99, 0) < noise_pct)
          sample_q.push_back(SAMPLE_W'($urandom));
        else if (k < low_len)
          sample_q.push_back(SAMPLE_W'($urandom_range(int'(trig_lvl), 0)));
        else
          sample_q.push_back(SAMPLE_W'($urandom_range(SAMPLE_TOP, int'(trig_lvl))));
        n--;
      end
    end
  endtask

  // Sample driver: predicts on acceptance, then offers the next request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) track_sample(sample_i);
      if (!in_valid_i || !in_stall_o) begin
        if (sample_q.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
          in_valid_i <= 1'b1;
          sample_i   <= sample_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
          sample_i   <= SAMPLE_W'($urandom);
        end
      end
    end
  end

  // Result monitor and receiver stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (mean_expect_q.size() == 0) begin
          note_error($sformatf("unexpected mean_frequency %0d", mean_frequency_o));
        end else begin
          want_freq = mean_expect_q.pop_front();
          if (mean_frequency_o !== want_freq)
            note_error($sformatf("mean_frequency mismatch: expected %0d, got %0d",
                                 want_freq, mean_frequency_o));
        end
      end
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99, 0) < idle_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    trig_lvl     = cfm_pkg::TRIGGER_RESET;
    rate_hz      = cfm_pkg::RATE_RESET;
    avg_num      = cfm_pkg::AVG_RESET;
    level_prev   = '0;
    period_count = '0;
    freq_sum     = '0;
    crossing_cnt = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset trigger and rate; first sample crosses with a count of one,
    // samples equal to the level cross, repeated level samples cross again
    write_reg(cfm_pkg::REG_AVERAGE, 24'd1);
    sample_q.push_back(8'd255); sample_q.push_back(8'd0);   sample_q.push_back(8'd128);
    sample_q.push_back(8'd128); sample_q.push_back(8'd127); sample_q.push_back(8'd129);
    sample_q.push_back(8'd0);   sample_q.push_back(8'd3);   sample_q.push_back(8'd200);
    drain();

    // Spare index ignored, upper data bits ignored, top trigger and rate,
    // zero average count behaves as one
    write_reg(REG_SPARE, 24'hFFFFFF);
    configure(24'h5A5AFF, 24'hFFFFFF, 24'hFFFF00);
    sample_q.push_back(8'd255); sample_q.push_back(8'd254);
    sample_q.push_back(8'd255); sample_q.push_back(8'd255);
    drain();

    // Zero trigger and zero rate
    configure(24'd0, 24'd0, 24'd3);
    sample_q.push_back(8'd0); sample_q.push_back(8'd0); sample_q.push_back(8'd9);
    sample_q.push_back(8'd0); sample_q.push_back(8'd7);
    drain();

    // Average count lowered while crossings are pending
    configure(24'd128, 24'd1000000, 24'd5);
    sample_q.push_back(8'd0); sample_q.push_back(8'd200); sample_q.push_back(8'd0);
    sample_q.push_back(8'd200); sample_q.push_back(8'd0); sample_q.push_back(8'd200);
    drain();
    write_reg(cfm_pkg::REG_AVERAGE, 24'd2);
    sample_q.push_back(8'd0); sample_q.push_back(8'd200);
    drain();

    // Random settings, short averages
    configure(DATA_W'($urandom_range(255, 0)), DATA_W'($urandom),
              DATA_W'($urandom_range(4, 1)));
    push_wave(150, 6, 6, 10);
    drain();

    // Same kind of traffic with no idling on either side
    idle_pct = 0;
    configure(DATA_W'($urandom_range(255, 0)), DATA_W'($urandom),
              DATA_W'($urandom_range(6, 1)));
    push_wave(150, 4, 4, 5);
    drain();
    idle_pct = 17;

    // Receiver holds off while dense crossings keep coming in
    configure(24'd128, DATA_W'($urandom), 24'd1);
    hold_req++;
    repeat (60) begin
      sample_q.push_back(SAMPLE_W'($urandom_range(127, 0)));
      sample_q.push_back(SAMPLE_W'($urandom_range(SAMPLE_TOP, 128)));
    end
    drain();

    // Largest average at full rate: every sample at the top level crosses
    configure(24'd255, 24'hFFFFFF, 24'd255);
    repeat (260) sample_q.push_back(8'd255);
    drain();

    // Random settings, longer periods
    configure(DATA_W'($urandom_range(255, 0)), DATA_W'($urandom),
              DATA_W'($urandom_range(10, 1)));
    push_wave(150, 12, 8, 8);
    drain();

    if (err_cnt == 0 && mean_expect_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
